// ----- rtl/core/address_lease_pool_macros.svh -----
// Assertion macros shared by the RTL of the address lease pool.
`ifndef ADDRESS_LEASE_POOL_MACROS_SVH
`define ADDRESS_LEASE_POOL_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge of clk, quiet while in reset.
`define ALP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true.
`define ALP_NEVER(label, cond, msg) \
    `ALP_ASSERT(label, !(cond), msg)

`else

`define ALP_ASSERT(label, prop, msg)

`define ALP_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/core/alp_pkg.sv -----
`timescale 1ns / 1ps

package alp_pkg;

    localparam int POOL_DEPTH    = 256;
    localparam int IDX_W         = $clog2(POOL_DEPTH);
    localparam int ACT_W         = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W         = (ACT_W > 9) ? ACT_W : 9;
    localparam int LEASE_MS_W    = 33;
    localparam int MS_PER_SECOND = 1000;
    localparam int PADDR_W       = 4;
    localparam int REG_IDX_W     = 2;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_DISCOVER = 2'd1,
        OP_REQUEST  = 2'd2,
        OP_OTHER    = 2'd3
    } opcode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE    = 2'd0,
        REG_COUNT   = 2'd1,
        REG_LEASE   = 2'd2,
        REG_TIMEOUT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        offered;
        logic        acked;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [31:0]           base;
        logic [ACT_W-1:0]      active_cnt;
        logic [LEASE_MS_W-1:0] lease_ms;
        logic [31:0]           offer_timeout;
    } cfg_t;

endpackage

// ----- rtl/core/alp_if.sv -----
`timescale 1ns / 1ps

interface alp_msg_if;
    import alp_pkg::*;

    logic        valid;
    logic        ready;
    opcode_t     opcode;
    logic [31:0] proposed_address;

    modport source (output valid, output opcode, output proposed_address, input ready);
    modport sink   (input valid, input opcode, input proposed_address, output ready);
endinterface

interface alp_reply_if;
    logic        valid;
    logic        ready;
    logic [31:0] assigned_address;
    logic        reply_is_ack;

    modport source (output valid, output assigned_address, output reply_is_ack, input ready);
    modport sink   (input valid, input assigned_address, input reply_is_ack, output ready);
endinterface

// ----- rtl/core/alp_ram.sv -----
`timescale 1ns / 1ps

module alp_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/alp_cfg.sv -----
`timescale 1ns / 1ps

module alp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output alp_pkg::cfg_t               cfg
);
    import alp_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RESET =
        (256 > POOL_DEPTH) ? ACT_W'(POOL_DEPTH) : ACT_W'(256);
    localparam logic [LEASE_MS_W-1:0] LEASE_MS_RESET = LEASE_MS_W'(3600 * MS_PER_SECOND);

    logic [31:0]           base_reg;
    logic [8:0]            count_reg;
    logic [22:0]           lease_reg;
    logic [31:0]           timeout_reg;
    logic [ACT_W-1:0]      act_reg;
    logic [LEASE_MS_W-1:0] lease_ms_reg;

    logic                  wr;
    reg_idx_t              reg_idx;
    logic [ACT_W-1:0]      act_next;
    logic [LEASE_MS_W-1:0] lease_ms_next;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // saturate the pool size at the memory depth
    assign act_next = (CMP_W'(count_reg) > CMP_W'(POOL_DEPTH)) ? ACT_W'(POOL_DEPTH)
                                                                : ACT_W'(count_reg);
    assign lease_ms_next = LEASE_MS_W'(lease_reg) * LEASE_MS_W'(MS_PER_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            count_reg    <= 9'd256;
            lease_reg    <= 23'd3600;
            timeout_reg  <= 32'd5000;
            act_reg      <= ACT_RESET;
            lease_ms_reg <= LEASE_MS_RESET;
        end
        else
        begin
            act_reg      <= act_next;
            lease_ms_reg <= lease_ms_next;
            if (wr)
            begin
                case (reg_idx)
                    REG_BASE:    base_reg    <= pwdata;
                    REG_COUNT:   count_reg   <= pwdata[8:0];
                    REG_LEASE:   lease_reg   <= pwdata[22:0];
                    REG_TIMEOUT: timeout_reg <= pwdata;
                    default:     ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BASE:    prdata = base_reg;
            REG_COUNT:   prdata = 32'(count_reg);
            REG_LEASE:   prdata = 32'(lease_reg);
            REG_TIMEOUT: prdata = timeout_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.base          = base_reg;
    assign cfg.active_cnt    = act_reg;
    assign cfg.lease_ms      = lease_ms_reg;
    assign cfg.offer_timeout = timeout_reg;

endmodule

// ----- rtl/core/address_lease_pool.sv -----
`timescale 1ns / 1ps

// Address lease pool: hands out addresses base, base+1, ... from a pool of up to
// POOL_DEPTH entries whose marks and time stamps sit in one memory with a
// registered read. A tick word only advances the current time. A request
// whose named address lies inside the pool first reads and checks that entry.
// Every discover, request or other word then walks the whole active pool once
// through the memory, one entry read and written back per cycle, to release
// expired entries and, for a discover or request not yet served, to give out
// the first free entry. A reply that finds the one before it still waiting holds
// the block until that one is taken. The address named by a request is found by
// subtraction, not by a search. After reset the block clears every memory entry
// and takes no word until that is done; register writes are taken throughout.
module address_lease_pool (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    alp_msg_if.sink                     msg_in,
    alp_reply_if.source                 reply_out
);
    import alp_pkg::*;

`include "address_lease_pool_macros.svh"

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REQ_RD,
        S_REQ_CHK,
        S_PASS,
        S_DONE
    } state_t;

    cfg_t cfg;

    alp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t           state_reg,    state_next;
    logic [IDX_W-1:0] clr_reg,      clr_next;
    opcode_t          op_reg,       op_next;
    logic [31:0]      prop_reg,     prop_next;
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic [ACT_W-1:0] rd_cnt_reg,   rd_cnt_next;
    logic             pend_reg,     pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             ack_done_reg, ack_done_next;
    logic             alloc_reg,    alloc_next;
    logic [31:0]      res_addr_reg, res_addr_next;
    logic [31:0]      now_reg,      now_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_addr_reg, out_addr_next;
    logic             out_ack_reg,  out_ack_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t      rd_entry;
    entry_t      wr_entry;
    logic [31:0] diff;
    logic        req_hit;
    logic [31:0] age;
    logic        issue;
    logic        serving;

    alp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_wdata = wr_entry;
    assign diff      = prop_reg - cfg.base;
    assign req_hit   = diff < 32'(cfg.active_cnt);
    assign age       = now_reg - rd_entry.stamp;
    assign issue     = rd_cnt_reg < cfg.active_cnt;
    assign serving   = (op_reg == OP_DISCOVER || op_reg == OP_REQUEST) && !ack_done_reg;

    assign msg_in.ready               = (state_reg == S_IDLE);
    assign reply_out.valid            = out_valid_reg;
    assign reply_out.assigned_address = out_addr_reg;
    assign reply_out.reply_is_ack     = out_ack_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        prop_next      = prop_reg;
        idx_next       = idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        ack_done_next  = ack_done_reg;
        alloc_next     = alloc_reg;
        res_addr_next  = res_addr_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !reply_out.ready;
        out_addr_next  = out_addr_reg;
        out_ack_next   = out_ack_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_raddr = rd_cnt_reg[IDX_W-1:0];
        wr_entry  = rd_entry;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                wr_entry  = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_cnt_next   = '0;
                ack_done_next = 1'b0;
                alloc_next    = 1'b0;
                if (msg_in.valid)
                begin
                    op_next   = msg_in.opcode;
                    prop_next = msg_in.proposed_address;
                    if (msg_in.opcode == OP_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    else if (msg_in.opcode == OP_REQUEST)
                    begin
                        state_next = S_REQ_RD;
                    end
                    else
                    begin
                        state_next = S_PASS;
                    end
                end
            end
            S_REQ_RD:
            begin
                // the proposed address maps to one entry only
                ram_raddr  = diff[IDX_W-1:0];
                idx_next   = diff[IDX_W-1:0];
                state_next = req_hit ? S_REQ_CHK : S_PASS;
            end
            S_REQ_CHK:
            begin
                if (rd_entry.offered && !rd_entry.acked)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = idx_reg;
                    wr_entry.acked = 1'b1;
                    wr_entry.stamp = now_reg;
                    ack_done_next  = 1'b1;
                    res_addr_next  = prop_reg;
                end
                state_next = S_PASS;
            end
            S_PASS:
            begin
                if (issue)
                begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                    if (serving && !alloc_reg && !rd_entry.offered && !rd_entry.acked)
                    begin
                        // first free entry goes to this word
                        wr_entry.offered = 1'b1;
                        wr_entry.acked   = (op_reg == OP_REQUEST);
                        wr_entry.stamp   = now_reg;
                        alloc_next       = 1'b1;
                        res_addr_next    = cfg.base + 32'(pend_idx_reg);
                    end
                    else if (rd_entry.offered && !rd_entry.acked)
                    begin
                        if (age > cfg.offer_timeout)
                        begin
                            wr_entry.offered = 1'b0;
                        end
                    end
                    else if (rd_entry.offered)
                    begin
                        if (LEASE_MS_W'(age) > cfg.lease_ms)
                        begin
                            wr_entry.offered = 1'b0;
                            wr_entry.acked   = 1'b0;
                        end
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (op_reg != OP_DISCOVER && op_reg != OP_REQUEST)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || reply_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = (ack_done_reg || alloc_reg) ? res_addr_reg : 32'd0;
                    out_ack_next   = (op_reg == OP_REQUEST);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            ack_done_reg  <= 1'b0;
            alloc_reg     <= 1'b0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            ack_done_reg  <= ack_done_next;
            alloc_reg     <= alloc_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        prop_reg     <= prop_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        res_addr_reg <= res_addr_next;
        out_addr_reg <= out_addr_next;
        out_ack_reg  <= out_ack_next;
    end

    `ALP_NEVER(a_no_word_while_clearing, state_reg == S_CLEAR && msg_in.ready, "word taken during clear")
    `ALP_NEVER(a_single_grant, ack_done_reg && alloc_reg, "request acked and allocated twice")
    `ALP_ASSERT(a_walk_in_range, state_reg == S_PASS |-> rd_cnt_reg <= cfg.active_cnt, "walk overran pool")
    `ALP_ASSERT(a_write_in_range, state_reg == S_PASS && pend_reg |-> ACT_W'(pend_idx_reg) < cfg.active_cnt, "write beyond pool")

endmodule
